### hw/rtl/b2d_pkg.sv
// b2d_pkg: shared types, constants and the bcd adjust function
// used by the dabble stages, the serializer and the top level
// no dependencies
package b2d_pkg;

    localparam int NUM_W       = 64;
    localparam int MIN_W       = 7;
    localparam int BCD_DIGITS  = 20;
    localparam int BCD_W       = 4 * BCD_DIGITS;
    localparam int STAGE_STEPS = 8;
    localparam int NUM_STAGES  = NUM_W / STAGE_STEPS;
    localparam int RUN_LIMIT   = 64;
    localparam logic [5:0] ASCII_ZERO = 6'd48;

    typedef struct packed {
        logic [NUM_W-1:0] bin;
        logic [BCD_W-1:0] bcd;
        logic [MIN_W-1:0] min_digits;
    } b2d_word_t;

    // add three to every digit of five or more
    function automatic logic [BCD_W-1:0] bcd_adjust(input logic [BCD_W-1:0] bcd);
        logic [BCD_W-1:0] res;
        res = bcd;
        for (int i = 0; i < BCD_DIGITS; i++)
        begin
            if (bcd[4*i +: 4] >= 4'd5)
            begin
                res[4*i +: 4] = bcd[4*i +: 4] + 4'd3;
            end
        end
        return res;
    endfunction

endpackage

### hw/rtl/b2d_dabble_stage.sv
// b2d_dabble_stage: one pipeline register stage doing several
// shift-and-add-3 steps of the binary to bcd conversion; uses b2d_pkg
module b2d_dabble_stage
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  b2d_pkg::b2d_word_t in_word,
    output logic               out_valid,
    input  logic               out_ready,
    output b2d_pkg::b2d_word_t out_word
);

    logic               valid_reg;
    b2d_pkg::b2d_word_t word_reg;
    b2d_pkg::b2d_word_t word_next;

    always_comb
    begin
        logic [b2d_pkg::BCD_W-1:0] bcd;
        logic [b2d_pkg::NUM_W-1:0] bin;
        bcd = in_word.bcd;
        bin = in_word.bin;
        for (int s = 0; s < b2d_pkg::STAGE_STEPS; s++)
        begin
            bcd = b2d_pkg::bcd_adjust(bcd);
            {bcd, bin} = {bcd, bin} << 1;
        end
        word_next.bcd        = bcd;
        word_next.bin        = bin;
        word_next.min_digits = in_word.min_digits;
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_word  = word_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            word_reg <= word_next;
        end
    end

endmodule

### hw/rtl/b2d_serializer.sv
// b2d_serializer: takes a finished bcd word and emits its ascii digits
// one per cycle while the master is ready, with padding, position and last; uses b2d_pkg
module b2d_serializer
#(
    parameter int MAX_DIGITS = 64
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [b2d_pkg::BCD_W-1:0] in_bcd,
    input  logic [b2d_pkg::MIN_W-1:0] in_min,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [5:0]                m_char,
    output logic [5:0]                m_pos,
    output logic                      m_last
);

    localparam int CAP_HI = (MAX_DIGITS > b2d_pkg::RUN_LIMIT) ? b2d_pkg::RUN_LIMIT : MAX_DIGITS;
    localparam int CAP    = (CAP_HI < b2d_pkg::BCD_DIGITS) ? b2d_pkg::BCD_DIGITS : CAP_HI;
    localparam logic [6:0] CAP_V = 7'(CAP);

    logic                      busy_reg;
    logic [b2d_pkg::BCD_W-1:0] bcd_reg;
    logic [6:0]                size_reg;
    logic [5:0]                k_reg;
    logic                      m_valid_reg;
    logic [5:0]                char_reg;
    logic [5:0]                pos_reg;
    logic                      last_reg;

    logic       can_emit;
    logic       cur_last;
    logic [6:0] idx;
    logic [3:0] digit;
    logic [6:0] nat;
    logic [6:0] wanted;
    logic [6:0] size_next;

    assign can_emit = !m_valid_reg || m_ready;
    assign cur_last = ({1'b0, k_reg} + 7'd1) == size_reg;
    assign in_ready = !busy_reg || (can_emit && cur_last);
    assign idx      = size_reg - 7'd1 - {1'b0, k_reg};

    always_comb
    begin
        // padding positions read as zero digits
        digit = 4'd0;
        if (idx < 7'(b2d_pkg::BCD_DIGITS))
        begin
            digit = bcd_reg[4*idx[4:0] +: 4];
        end
    end

    always_comb
    begin
        nat = 7'd1;
        for (int i = 0; i < b2d_pkg::BCD_DIGITS; i++)
        begin
            if (in_bcd[4*i +: 4] != 4'd0)
            begin
                nat = 7'(i + 1);
            end
        end
        wanted    = (in_min > CAP_V) ? CAP_V : in_min;
        size_next = (wanted > nat) ? wanted : nat;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
            k_reg       <= 6'd0;
        end
        else
        begin
            if (can_emit)
            begin
                m_valid_reg <= busy_reg;
            end
            // a new run starts as the previous one hands over its last character
            if (in_ready && in_valid)
            begin
                busy_reg <= 1'b1;
                k_reg    <= 6'd0;
            end
            else if (busy_reg && can_emit)
            begin
                k_reg <= k_reg + 6'd1;
                if (cur_last)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (busy_reg && can_emit)
        begin
            char_reg <= b2d_pkg::ASCII_ZERO + {2'b00, digit};
            pos_reg  <= k_reg;
            last_reg <= cur_last;
        end
        if (in_ready && in_valid)
        begin
            bcd_reg  <= in_bcd;
            size_reg <= size_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_char  = char_reg;
    assign m_pos   = pos_reg;
    assign m_last  = last_reg;

    a_busy_size: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (size_reg != 7'd0) && ({1'b0, k_reg} < size_reg))
        else $error("serializer index beyond run");

    a_char_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_valid_reg |-> (char_reg >= 6'd48) && (char_reg <= 6'd57))
        else $error("character not a decimal digit");

    a_pos_step: assert property (@(posedge clk) disable iff (!rst_n)
        (m_valid_reg && m_ready && !last_reg) |=>
            (m_valid_reg && (pos_reg == $past(pos_reg) + 6'd1)))
        else $error("run broken before last");

endmodule

### hw/rtl/binary_to_decimal_ascii.sv
// binary_to_decimal_ascii: top level, unsigned 64-bit to decimal ascii
// built from b2d_dabble_stage, b2d_serializer and b2d_pkg
//
// usage
// - slave channel takes one word: the number and a minimum digit count
// - master channel gives one word per character, most significant first,
//   with its position in the run and tlast on the final character
// - conversion runs through an 8 stage shift-and-add-3 pipeline, 8 steps
//   per stage, so a new number can enter every cycle while the pipe flows
// - a number passes the stage registers, then the serializer's run and
//   output registers before its first character; an item gives 1 to 64
//   characters, emitted one per cycle while the master is ready
// - min_digits above the cap (MAX_DIGITS clamped to 20..64) saturates there
// - reset clears all valid bits; no words are in flight afterwards
// - a stalled master holds the current character; the serializer and then
//   the pipeline stages fill up and s_tready drops, nothing is lost
module binary_to_decimal_ascii
#(
    parameter int MAX_DIGITS = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // number[63:0], min_digits[70:64], zero[71]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // character[5:0], position[11:6], zero[15:12]
    output logic        m_tlast
);

    localparam int NS = b2d_pkg::NUM_STAGES;

    b2d_pkg::b2d_word_t word  [NS+1];
    logic               valid [NS+1];
    logic               ready [NS+1];

    logic [5:0] ch;
    logic [5:0] pos;

    // entry word: bcd accumulator starts at zero
    assign word[0].bin        = s_tdata[63:0];
    assign word[0].bcd        = '0;
    assign word[0].min_digits = s_tdata[70:64];
    assign valid[0]           = s_tvalid;
    assign s_tready           = ready[0];

    for (genvar g = 0; g < NS; g++)
    begin : g_stage
        b2d_dabble_stage u_stage
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (valid[g]),
            .in_ready  (ready[g]),
            .in_word   (word[g]),
            .out_valid (valid[g+1]),
            .out_ready (ready[g+1]),
            .out_word  (word[g+1])
        );
    end

    b2d_serializer #(.MAX_DIGITS(MAX_DIGITS)) u_ser
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (valid[NS]),
        .in_ready (ready[NS]),
        .in_bcd   (word[NS].bcd),
        .in_min   (word[NS].min_digits),
        .m_valid  (m_tvalid),
        .m_ready  (m_tready),
        .m_char   (ch),
        .m_pos    (pos),
        .m_last   (m_tlast)
    );

    assign m_tdata = {4'b0000, pos, ch};

endmodule
